// ----- rtl/scfc_pkg.sv -----
// Package for the sensor frame CRC checker: result item type, CRC constants
// and the bytewise MODBUS CRC-16 update function.
// No dependencies.
package scfc_pkg;

  localparam int          CNT_W    = 7;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef struct packed {
    logic [5:0]  word_index;
    logic [15:0] word_value;
    logic        last;
    logic        crc_ok;
    logic [15:0] computed_crc;
  } scfc_result_t;

  // Reflected CRC-16, one byte, eight shift/xor steps unrolled.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/sensor_frame_crc_checker.sv -----
// Top level of the sensor frame CRC checker: stream ports, frame core and
// output buffer. Depends on scfc_pkg, scfc_core, scfc_out_buf.
//
//   channel | dir | tdata                                   | tuser       | tlast
//   in_     | in  | rx_byte[7:0]                            | frame_start | -
//   out_    | out | word_index, word_value, computed_crc    | crc_ok      | last
//
// One byte item accepted per cycle while in_tready is high; a result item
// reaches out_ through the input register and then the output register
// after the odd-position byte is accepted. The throughput is set by the
// combinational CRC byte update in scfc_core.
// rst_n is synchronous: CRC returns to 0xFFFF, byte counter to zero.
// A two-entry output buffer absorbs output stalls; input stalls only once
// both entries and the input register are full.
module sensor_frame_crc_checker #(
  parameter int FRAME_BYTES = 86
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [5:0] word_index, [21:6] word_value,
                                  // [37:22] computed_crc, [39:38] zero
  output logic        out_tuser,  // [0] crc_ok
  output logic        out_tlast   // last
);
  import scfc_pkg::*;

  logic         push, buf_full;
  scfc_result_t core_res, out_res;

  scfc_core #(.FRAME_BYTES(FRAME_BYTES)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_start (in_tuser),
    .in_ready (in_tready),
    .buf_full (buf_full),
    .push     (push),
    .res      (core_res)
  );

  scfc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (core_res),
    .full      (buf_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {2'b00, out_res.computed_crc, out_res.word_value, out_res.word_index};
  assign out_tuser = out_res.crc_ok;
  assign out_tlast = out_res.last;

endmodule

// ----- rtl/scfc_core.sv -----
// Input register, frame state (CRC, byte counter, low byte) and the word
// assembly / checksum compare logic feeding the output buffer.
// Depends on scfc_pkg.
module scfc_core #(
  parameter int FRAME_BYTES = 86
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [7:0]           in_byte,
  input  logic                 in_start,
  output logic                 in_ready,
  input  logic                 buf_full,
  output logic                 push,
  output scfc_pkg::scfc_result_t res
);
  import scfc_pkg::*;

  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_BYTES - 1);
  localparam logic [CNT_W-1:0] CRC_END  = CNT_W'(FRAME_BYTES - 2);

  logic             in_valid_r;
  logic [7:0]       byte_r;
  logic             start_r;

  logic [15:0]      crc_r, crc_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       low_r, low_nxt;

  logic             advance;
  logic [15:0]      crc_base, crc_upd;
  logic [CNT_W-1:0] pos;
  logic [15:0]      word;
  logic             is_last;

  assign advance  = in_valid_r && !buf_full;
  assign in_ready = !in_valid_r || !buf_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      byte_r  <= in_byte;
      start_r <= in_start;
    end
  end

  always_comb begin
    crc_base = start_r ? CRC_INIT : crc_r;
    pos      = start_r ? '0 : count_r;
    crc_upd  = (pos < CRC_END) ? crc16_byte(crc_base, byte_r) : crc_base;
    word     = {byte_r, low_r};
    is_last  = (pos == LAST_POS);

    low_nxt  = pos[0] ? low_r : byte_r;
    if (pos >= LAST_POS) begin
      count_nxt = '0;
      crc_nxt   = CRC_INIT;
    end else begin
      count_nxt = pos + 1'b1;
      crc_nxt   = crc_upd;
    end

    push             = advance && pos[0];
    res.word_index   = pos[6:1];
    res.word_value   = word;
    res.last         = is_last;
    res.crc_ok       = is_last && (word == crc_upd);
    res.computed_crc = crc_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_INIT;
      count_r <= '0;
      low_r   <= '0;
    end else if (advance) begin
      crc_r   <= crc_nxt;
      count_r <= count_nxt;
      low_r   <= low_nxt;
    end
  end

endmodule

// ----- rtl/scfc_out_buf.sv -----
// Two-entry output buffer (output register plus skid register) for result
// items; full flag is registered so the upstream stall path stays short.
// Depends on scfc_pkg.
module scfc_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  scfc_pkg::scfc_result_t push_data,
  output logic                   full,
  output logic                   out_valid,
  input  logic                   out_ready,
  output scfc_pkg::scfc_result_t out_data
);
  import scfc_pkg::*;

  logic         main_valid_r, skid_valid_r;
  scfc_result_t main_r, skid_r;
  logic         pop;

  assign pop       = main_valid_r && out_ready;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= push;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_r <= skid_r;
        if (push) begin
          skid_r <= push_data;
        end
      end else if (push) begin
        main_r <= push_data;
      end
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule

// ----- rtl/scfc_checker.sv -----
// Port-level checker for the sensor frame CRC checker, bound to the top level.
// Depends on sensor_frame_crc_checker only through the bind below.
module scfc_checker #(
  parameter int FRAME_BYTES = 86
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  localparam logic [5:0] LAST_IDX = 6'((FRAME_BYTES - 1) / 2);

  // no result may come out of the cycle after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // crc_ok is only meaningful on the checksum word
  a_ok_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("crc_ok set on a non-final word");

  // checksum word always carries the final word index
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[5:0] == LAST_IDX)
    else $error("final word has wrong index");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result item changed");

endmodule

bind sensor_frame_crc_checker scfc_checker #(.FRAME_BYTES(FRAME_BYTES)) u_scfc_checker (.*);
